>>> rtl/mpm_pkg.sv
// Package: signature constants, match helper functions and shared types.
`timescale 1ns / 1ps

package mpm_pkg;

    // Total signature characters and the width of the progress vector.
    localparam int SIG_BITS = 47;

    // Signatures back to back; character k sits at bits [8*(SIG_BITS-1-k) +: 8].
    localparam logic [8*SIG_BITS-1:0] SIG_CHARS =
        "rm -rfdel /sformatgit reset --hardgit clean -fd";

    // First and last bit of each signature segment.
    localparam logic [SIG_BITS-1:0] SIG_STARTS = 47'h0_0004_0004_1041;
    localparam logic [SIG_BITS-1:0] SIG_ENDS   = 47'h4002_0002_0820;

    typedef struct packed {
        logic [7:0] char_code;
        logic       char_valid;
        logic       last_char;
    } t_req_item;

    typedef struct packed {
        logic      valid;
        t_req_item item;
    } t_stage;

    // Fold ASCII upper case to lower case; everything else passes unchanged.
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] f;
        f = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            f = c | 8'h20;
        end
        return f;
    endfunction

    // Bit k set when the folded byte equals signature character k.
    function automatic logic [SIG_BITS-1:0] char_mask(input logic [7:0] c);
        logic [SIG_BITS-1:0] m;
        logic [7:0]          f;
        m = '0;
        f = fold_case(c);
        for (int k = 0; k < SIG_BITS; k++) begin
            m[k] = (fold_case(SIG_CHARS[8*(SIG_BITS-1-k) +: 8]) == f);
        end
        return m;
    endfunction

endpackage

>>> rtl/mpm_channels.sv
// Interfaces: request and result channels with valid/ready handshake.
`timescale 1ns / 1ps

interface mpm_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       char_valid;
    logic       last_char;

    modport source (output valid, output char_code, output char_valid,
                    output last_char, input ready);
    modport sink   (input valid, input char_code, input char_valid,
                    input last_char, output ready);
endinterface

interface mpm_rsp_if;
    logic valid;
    logic ready;
    logic dangerous;

    modport source (output valid, output dangerous, input ready);
    modport sink   (input valid, input dangerous, output ready);
endinterface

>>> rtl/mpm_in_reg.sv
// Input register: holds one accepted request until the scan stage takes it.
`timescale 1ns / 1ps

module mpm_in_reg
    import mpm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_req_item i_item,
    input  logic      i_advance,
    output logic      o_ready,
    output t_stage    o_stage
);

    logic      r_valid;
    t_req_item r_item;

    assign o_ready       = !r_valid || i_advance;
    assign o_stage.valid = r_valid;
    assign o_stage.item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

>>> rtl/mpm_scan.sv
// Scan stage: shift-and progress over all signatures plus the sticky hit flag.
`timescale 1ns / 1ps

module mpm_scan
    import mpm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_req_item i_item,
    output logic      o_dangerous
);

    logic [SIG_BITS-1:0] r_progress;
    logic                r_hit;
    logic [SIG_BITS-1:0] n_progress;
    logic                n_hit;

    always_comb begin
        n_progress = r_progress;
        n_hit      = r_hit;
        if (i_item.char_valid) begin
            n_progress = ({r_progress[SIG_BITS-2:0], 1'b0} | SIG_STARTS)
                         & char_mask(i_item.char_code);
            n_hit      = r_hit || (|(n_progress & SIG_ENDS));
        end
    end

    assign o_dangerous = n_hit;

    // Clear on the last byte of a text, else advance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_progress <= '0;
            r_hit      <= 1'b0;
        end else if (i_fire) begin
            if (i_item.last_char) begin
                r_progress <= '0;
                r_hit      <= 1'b0;
            end else begin
                r_progress <= n_progress;
                r_hit      <= n_hit;
            end
        end
    end

endmodule

>>> rtl/mpm_out_reg.sv
// Result register: holds one verdict until the sink takes it.
`timescale 1ns / 1ps

module mpm_out_reg (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  logic i_dangerous,
    input  logic i_ready,
    output logic o_free,
    output logic o_valid,
    output logic o_dangerous
);

    logic r_valid;
    logic r_dangerous;

    assign o_free      = !r_valid || i_ready;
    assign o_valid     = r_valid;
    assign o_dangerous = r_dangerous;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_dangerous <= i_dangerous;
        end
    end

endmodule

>>> rtl/multi_pattern_matcher_unit.sv
// Top level: case-insensitive multi-signature substring detector.
`timescale 1ns / 1ps

// Streams a command text one byte per request and flags whether any of five
// signatures ("rm -rf", "del /s", "format", "git reset --hard",
// "git clean -fd") occurs in it, ignoring ASCII letter case. Send the text
// with last_char set on its final request; that request yields exactly one
// result, dangerous, and the matcher then starts afresh. An empty text is a
// single request with char_valid 0 and last_char 1 and gives 0. Requests with
// char_valid 0 leave the match state untouched. Throughput is one request per
// cycle while the input side does not stall. A result is valid once the
// request closing its text is accepted and advanced: the accepting edge loads
// the input register, and the edge that advances it runs the 47-wide shift-and
// compare into the result register. The input side stalls only while a result
// waits in the result register and another last request is queued behind it.
module multi_pattern_matcher_unit
    import mpm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    mpm_req_if.sink      i_req,
    mpm_rsp_if.source    o_rsp
);

    t_req_item req_item;
    t_stage    stage;
    logic      advance;
    logic      out_free;
    logic      scan_dangerous;

    assign req_item.char_code  = i_req.char_code;
    assign req_item.char_valid = i_req.char_valid;
    assign req_item.last_char  = i_req.last_char;

    // Advance the held request unless it ends a text and the result slot is busy.
    assign advance = stage.valid && (!stage.item.last_char || out_free);

    mpm_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_req.valid),
        .i_item    (req_item),
        .i_advance (advance),
        .o_ready   (i_req.ready),
        .o_stage   (stage)
    );

    mpm_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (advance),
        .i_item      (stage.item),
        .o_dangerous (scan_dangerous)
    );

    // Load a verdict only for the request that closes a text.
    mpm_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance && stage.item.last_char),
        .i_dangerous (scan_dangerous),
        .i_ready     (o_rsp.ready),
        .o_free      (out_free),
        .o_valid     (o_rsp.valid),
        .o_dangerous (o_rsp.dangerous)
    );

endmodule

>>> rtl/mpm_checker.sv
// Checker: port-level properties of the matcher, bound to the top level.
`timescale 1ns / 1ps

module mpm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_ready,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input logic i_rsp_dangerous
);

    // A stalled result holds its value.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_dangerous))
        else $error("result changed while stalled");

    // No result right after reset.
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid after reset");

    // The input side backs up only behind a stalled result.
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req_ready |-> i_rsp_valid && !i_rsp_ready)
        else $error("request stalled without a waiting result");

    // A new result comes from a cycle in which the input stage moved.
    a_rsp_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> $past(i_req_ready))
        else $error("result appeared without stage advance");

endmodule

bind multi_pattern_matcher_unit mpm_checker u_mpm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_dangerous (o_rsp.dangerous)
);
